### sv/bud_pkg.sv
// shared types, status codes and helpers for the buddy allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bud_pkg;

    localparam int WORD_BITS = 32;
    localparam int ORD_W     = 5;
    localparam int ST_W      = 3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_NOMEM  = 3'd1;
    localparam logic [ST_W-1:0] ST_BADARG = 3'd2;
    localparam logic [ST_W-1:0] ST_DOUBLE = 3'd3;
    localparam logic [ST_W-1:0] ST_RANGE  = 3'd4;

    typedef struct packed {
        logic              req_type;
        logic [ORD_W-1:0]  block_order;
        logic [31:0]       address;
    } t_req;

    typedef struct packed {
        logic [31:0]       block_address;
        logic [ST_W-1:0]   status;
    } t_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_A_SCAN,
        S_A_RD,
        S_A_PICK,
        S_A_SPLIT,
        S_SU_RD,
        S_SU_CHK,
        S_SU_LNK,
        S_SU_CLR,
        S_SU_RET,
        S_SF_RD,
        S_SF_CHK,
        S_SF_LNK,
        S_F_RD,
        S_F_TEST,
        S_F_UNL,
        S_DONE
    } t_state;

    // index of lowest set bit, 31 when none
    function automatic logic [4:0] lsb_index(logic [WORD_BITS-1:0] v);
        logic [4:0] r;
        r = 5'd31;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) r = 5'(i);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/bud_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bud_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_re) o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### sv/bud_ctrl.sv
// sequencer of the buddy allocator: list heads, word valid bits and the three rams
// depends on bud_pkg and bud_ram
`timescale 1ns / 1ps
`default_nettype none

module bud_ctrl #(
    parameter int MIN_ORDER  = 6,
    parameter int MAX_ORDER  = 12,
    parameter int TOP_BLOCKS = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [31:0]   i_heap_base,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire bud_pkg::t_req i_req,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_ready,
    output bud_pkg::t_rsp      o_rsp
);

    import bud_pkg::*;

    function automatic int words_of(int o);
        int b;
        b = TOP_BLOCKS << (MAX_ORDER - o);
        return (b + WORD_BITS - 1) >> 5;
    endfunction

    function automatic int base_of(int o);
        int s;
        s = 0;
        for (int j = MAX_ORDER; j > o; j--) s += words_of(j);
        return s;
    endfunction

    localparam int NUM   = MAX_ORDER - MIN_ORDER + 1;
    localparam int HI_W  = (NUM > 1) ? $clog2(NUM) : 1;
    localparam int DEPTH = base_of(MIN_ORDER - 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int LNK_W = $clog2(words_of(MIN_ORDER)) + 1;
    localparam int BLK_W = $clog2(TOP_BLOCKS << (MAX_ORDER - MIN_ORDER));
    localparam logic [LNK_W-1:0] NIL  = {LNK_W{1'b1}};
    localparam logic [32:0]      POOL = 33'(TOP_BLOCKS) << MAX_ORDER;
    localparam logic [ORD_W-1:0] OMIN = ORD_W'(MIN_ORDER);
    localparam logic [ORD_W-1:0] OMAX = ORD_W'(MAX_ORDER);

    t_state r_state, n_state;

    logic             r_req;
    logic [ORD_W-1:0] r_ord, r_lvl, r_top;
    logic [31:0]      r_addr_in;
    logic [BLK_W-1:0] r_blk, r_blk0, r_tgt;
    logic [LNK_W-1:0] r_oldhead;
    logic [LNK_W-1:0] r_head [NUM];
    logic [DEPTH-1:0] r_wvalid;
    logic [ST_W-1:0]  r_status;
    logic [31:0]      r_res;

    logic [AW-1:0]    w_base [NUM];
    logic [HI_W-1:0]  hsel;
    logic [LNK_W-1:0] cur_head;
    logic [AW-1:0]    cur_base;
    logic [31:0]      tgt32;
    logic [LNK_W-1:0] t_idx;
    logic [4:0]       t_bit;
    logic [AW-1:0]    t_w;
    logic [31:0]      av_rdata, avail_was, avail_now, bmask;
    logic [LNK_W-1:0] pv_rdata, nx_rdata;
    logic [31:0]      off;
    logic             f_mis, f_oob, bad_ord;

    logic             av_we, av_re, pv_we, nx_we, ln_re;
    logic [AW-1:0]    av_waddr, av_raddr, pv_waddr, nx_waddr;
    logic [31:0]      av_wdata;
    logic [LNK_W-1:0] pv_wdata, nx_wdata;

    for (genvar g = 0; g < NUM; g++) begin : g_base
        assign w_base[g] = AW'(base_of(MIN_ORDER + g));
    end

    assign hsel      = HI_W'(r_lvl - OMIN);
    assign cur_head  = r_head[hsel];
    assign cur_base  = w_base[hsel];
    assign tgt32     = 32'(r_tgt);
    assign t_idx     = LNK_W'(tgt32 >> 5);
    assign t_bit     = tgt32[4:0];
    assign t_w       = cur_base + AW'(t_idx);
    assign avail_was = r_wvalid[t_w] ? av_rdata : '0;
    assign bmask     = 32'd1 << t_bit;
    assign avail_now = avail_was & ~bmask;
    assign off       = r_addr_in - i_heap_base;
    assign f_mis     = (off & ~(32'hFFFF_FFFF << r_ord)) != 32'd0;
    assign f_oob     = {1'b0, off} >= POOL;
    assign bad_ord   = (r_ord < OMIN) || (r_ord > OMAX);

    bud_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_avail (
        .i_clk(i_clk), .i_we(av_we), .i_waddr(av_waddr), .i_wdata(av_wdata),
        .i_re(av_re), .i_raddr(av_raddr), .o_rdata(av_rdata)
    );

    bud_ram #(.WIDTH(LNK_W), .DEPTH(DEPTH)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_re(ln_re), .i_raddr(t_w), .o_rdata(pv_rdata)
    );

    bud_ram #(.WIDTH(LNK_W), .DEPTH(DEPTH)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_re(ln_re), .i_raddr(t_w), .o_rdata(nx_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_req_valid) n_state = S_CHECK;
            S_CHECK: begin
                if (bad_ord) n_state = S_DONE;
                else if (r_req == REQ_ALLOC) n_state = S_A_SCAN;
                else if (f_mis || f_oob) n_state = S_DONE;
                else n_state = S_F_RD;
            end
            S_A_SCAN: begin
                if (cur_head != NIL) n_state = S_A_RD;
                else if (r_lvl == OMAX) n_state = S_DONE;
            end
            S_A_RD:    n_state = S_A_PICK;
            S_A_PICK:  n_state = S_SU_CHK;
            S_A_SPLIT: n_state = (r_lvl > r_ord) ? S_SF_RD : S_DONE;
            S_SU_RD:   n_state = S_SU_CHK;
            S_SU_CHK: begin
                if (avail_was != 32'd0 && avail_now == 32'd0) n_state = S_SU_LNK;
                else n_state = S_SU_RET;
            end
            S_SU_LNK:  n_state = S_SU_CLR;
            S_SU_CLR:  n_state = S_SU_RET;
            S_SU_RET:  n_state = (r_req == REQ_ALLOC) ? S_A_SPLIT : S_F_UNL;
            S_SF_RD:   n_state = S_SF_CHK;
            S_SF_CHK: begin
                if (avail_was == 32'd0 && cur_head != NIL) n_state = S_SF_LNK;
                else n_state = (r_req == REQ_ALLOC) ? S_A_SPLIT : S_DONE;
            end
            S_SF_LNK:  n_state = (r_req == REQ_ALLOC) ? S_A_SPLIT : S_DONE;
            S_F_RD:    n_state = S_F_TEST;
            S_F_TEST: begin
                if (avail_was[t_bit]) n_state = S_DONE;
                else if (r_lvl == OMAX || !avail_was[t_bit ^ 5'd1]) n_state = S_F_UNL;
                else n_state = S_F_RD;
            end
            S_F_UNL:   n_state = (r_lvl < r_top) ? S_SU_RD : S_SF_RD;
            S_DONE:    if (i_rsp_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // ram controls
    always_comb begin
        av_we    = 1'b0;
        av_re    = 1'b0;
        pv_we    = 1'b0;
        nx_we    = 1'b0;
        ln_re    = 1'b0;
        av_waddr = t_w;
        av_raddr = t_w;
        av_wdata = avail_now;
        pv_waddr = t_w;
        pv_wdata = NIL;
        nx_waddr = t_w;
        nx_wdata = NIL;
        case (r_state)
            S_A_RD: begin
                av_re    = 1'b1;
                av_raddr = cur_base + AW'(cur_head);
            end
            S_SU_RD, S_SF_RD, S_F_RD: av_re = 1'b1;
            S_SU_CHK: begin
                av_we = 1'b1;
                ln_re = 1'b1;
            end
            S_SU_LNK: begin
                nx_we    = pv_rdata != NIL;
                nx_waddr = cur_base + AW'(pv_rdata);
                nx_wdata = nx_rdata;
                pv_we    = nx_rdata != NIL;
                pv_waddr = cur_base + AW'(nx_rdata);
                pv_wdata = pv_rdata;
            end
            S_SU_CLR: begin
                pv_we = 1'b1;
                nx_we = 1'b1;
            end
            S_SF_CHK: begin
                av_we    = 1'b1;
                av_wdata = avail_was | bmask;
                pv_we    = avail_was == 32'd0;
                nx_we    = avail_was == 32'd0;
                nx_wdata = cur_head;
            end
            S_SF_LNK: begin
                pv_we    = 1'b1;
                pv_waddr = cur_base + AW'(r_oldhead);
                pv_wdata = t_idx;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wvalid <= '0;
            r_lvl    <= OMIN;
            for (int i = 0; i < NUM; i++) r_head[i] <= NIL;
        end else begin
            r_state <= n_state;
            if (av_we) r_wvalid[t_w] <= 1'b1;
            case (r_state)
                S_CHECK:  if (!bad_ord) r_lvl <= r_ord;
                S_A_SCAN: if (cur_head == NIL && r_lvl != OMAX) r_lvl <= r_lvl + 5'd1;
                S_A_SPLIT: if (r_lvl > r_ord) r_lvl <= r_lvl - 5'd1;
                S_SU_LNK: begin
                    if (pv_rdata == NIL && cur_head == t_idx) r_head[hsel] <= nx_rdata;
                end
                S_SU_RET: if (r_req == REQ_FREE) r_lvl <= r_lvl + 5'd1;
                S_SF_CHK: if (avail_was == 32'd0) r_head[hsel] <= t_idx;
                S_F_TEST: begin
                    if (!avail_was[t_bit]) begin
                        if (r_lvl == OMAX || !avail_was[t_bit ^ 5'd1]) r_lvl <= r_ord;
                        else r_lvl <= r_lvl + 5'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    r_req     <= i_req.req_type;
                    r_ord     <= i_req.block_order;
                    r_addr_in <= i_req.address;
                end
            end
            S_CHECK: begin
                r_res    <= 32'd0;
                r_status <= ST_OK;
                r_tgt    <= BLK_W'(off >> r_ord);
                r_blk0   <= BLK_W'(off >> r_ord);
                if (bad_ord || (r_req == REQ_FREE && f_mis)) r_status <= ST_BADARG;
                else if (r_req == REQ_FREE && f_oob) r_status <= ST_RANGE;
            end
            S_A_SCAN: if (cur_head == NIL && r_lvl == OMAX) r_status <= ST_NOMEM;
            S_A_PICK: begin
                r_tgt <= BLK_W'((32'(cur_head) << 5) | 32'(lsb_index(av_rdata)));
                r_blk <= BLK_W'((32'(cur_head) << 5) | 32'(lsb_index(av_rdata)));
            end
            S_A_SPLIT: begin
                if (r_lvl > r_ord) begin
                    r_blk <= r_blk << 1;
                    r_tgt <= (r_blk << 1) | BLK_W'(1);
                end else begin
                    r_res <= i_heap_base + (32'(r_blk) << r_ord);
                end
            end
            S_SU_RET: if (r_req == REQ_FREE) r_blk <= r_blk >> 1;
            S_SF_CHK: r_oldhead <= cur_head;
            S_F_TEST: begin
                if (avail_was[t_bit]) r_status <= ST_DOUBLE;
                else if (r_lvl == OMAX || !avail_was[t_bit ^ 5'd1]) begin
                    r_top <= r_lvl;
                    r_blk <= r_blk0;
                end else begin
                    r_tgt <= r_tgt >> 1;
                end
            end
            S_F_UNL: r_tgt <= (r_lvl < r_top) ? (r_blk ^ BLK_W'(1)) : r_blk;
            default: ;
        endcase
    end

    assign o_req_ready         = r_state == S_IDLE;
    assign o_rsp_valid         = r_state == S_DONE;
    assign o_rsp.block_address = r_res;
    assign o_rsp.status        = r_status;

    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lvl >= OMIN) && (r_lvl <= OMAX))
        else $error("order level out of range");

    a_head_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_PICK) |-> (av_rdata != 32'd0))
        else $error("listed word has no free block");

    a_old_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SF_LNK) |-> (r_oldhead != NIL))
        else $error("relink of empty list");

endmodule

`default_nettype wire

### sv/buddy_allocator_core.sv
// Buddy allocator for blocks of 2^MIN_ORDER to 2^MAX_ORDER bytes over TOP_BLOCKS top blocks
// from heap_base. One request is in flight at a time; s_axis_tready is high only while the
// sequencer is idle. A request with a bad argument goes from the check straight to done; an
// allocate may split through every order and a free may merge up to the top, and either may
// wait for the output register: each order step costs a registered read of the availability
// ram plus a bit and list update in the shared sequencer. The pool starts empty after reset;
// software frees every top block first. The result waits in an output register.
// depends on bud_pkg and bud_ctrl
`timescale 1ns / 1ps
`default_nettype none

module buddy_allocator_core #(
    parameter int MIN_ORDER  = 6,
    parameter int MAX_ORDER  = 12,
    parameter int TOP_BLOCKS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,     // heap_base
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // block_order[4:0], address[36:5], zero pad
    input  wire logic        s_axis_tuser,   // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // block_address[31:0], status[34:32], zero pad
);

    import bud_pkg::*;

    logic [31:0] r_heap_base;
    logic        r_m_valid;
    t_rsp        r_m_data;
    t_req        req;
    t_rsp        rsp;
    logic        rsp_valid;

    assign req.req_type    = s_axis_tuser;
    assign req.block_order = s_axis_tdata[4:0];
    assign req.address     = s_axis_tdata[36:5];

    bud_ctrl #(
        .MIN_ORDER(MIN_ORDER), .MAX_ORDER(MAX_ORDER), .TOP_BLOCKS(TOP_BLOCKS)
    ) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_heap_base(r_heap_base),
        .i_req_valid(s_axis_tvalid), .o_req_ready(s_axis_tready), .i_req(req),
        .o_rsp_valid(rsp_valid), .i_rsp_ready(!r_m_valid), .o_rsp(rsp)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= 32'd0;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) r_heap_base <= i_cfg_data;
            if (rsp_valid && !r_m_valid) r_m_valid <= 1'b1;
            else if (m_axis_tready) r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_valid && !r_m_valid) r_m_data <= rsp;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {5'd0, r_m_data.status, r_m_data.block_address};

endmodule

`default_nettype wire
